@@ hdl/amt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amt_pkg
// Shared types and constants of the adaptive mean threshold block.
// ----------------------------------------------------------------------------
package amt_pkg;

    // input item kinds
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd2;
    localparam logic [1:0] REG_OFFSET       = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // register reset values
    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [4:0]  RST_BLOCK_SIZE   = 5'd21;
    localparam logic [8:0]  RST_OFFSET       = 9'd10;

    localparam logic [7:0] PIX_BLACK = 8'h00;
    localparam logic [7:0] PIX_WHITE = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LATCH,
        ST_CALC,
        ST_DECIDE,
        ST_READ,
        ST_CENTER,
        ST_MUL,
        ST_RESULT
    } amt_state_t;

endpackage
`default_nettype wire

@@ hdl/adaptive_mean_threshold.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_mean_threshold
// Streaming adaptive mean threshold of a grey image into a binary image.
// ----------------------------------------------------------------------------
// Pixels enter in raster order (s_tuser = 0) and are kept in a ring of
// 2**clog2(MAX_BLOCK+1) rows of the line store; flush items (s_tuser = 1)
// drain the pending outputs after the last pixel of a frame. Each output
// pixel is 0 or 255 and leaves h*width+h pixels after its own, with m_tlast
// on the last pixel of the frame. Frame size, block size and offset are
// sampled at the first pixel of each frame. An item with no result passes
// the decide state only; a border result adds the result state, the first
// pixel of a frame the settings latch and calc states, and an interior
// result the read, center and multiply states: the window is summed one
// pixel per cycle through the single line-store read port. A result waiting
// at the output does not block the next item until that item has its own
// result ready; then the block holds until the waiting result is taken.
// ----------------------------------------------------------------------------
module adaptive_mean_threshold #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_BLOCK  = 31
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [amt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [amt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [7:0] pixel
    input  wire logic                               s_tuser,   // [0] command
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [7:0]                              m_tdata,   // [7:0] binary_value
    output logic                                    m_tlast
);

    localparam int WW   = $clog2(MAX_WIDTH+1);
    localparam int HW   = $clog2(MAX_HEIGHT+1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int BW   = $clog2(MAX_BLOCK+1);
    localparam int RA   = BW;
    localparam int AW   = RA + CW;
    localparam int XW   = RW + RA;
    localparam int CNTW = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
    localparam int DLW  = WW + BW;
    localparam int DVW  = 2 * BW;
    localparam int SW   = $clog2(MAX_BLOCK*MAX_BLOCK*255+1);
    localparam int PW   = 10 + DVW;

    amt_pkg::amt_state_t state_reg, state_next;

    logic [WW-1:0]   frm_w;
    logic [HW-1:0]   frm_h;
    logic [BW-1:0]   frm_half;
    logic signed [8:0] frm_off;
    logic [CNTW-1:0] frm_total;
    logic [DLW-1:0]  frm_delay;
    logic [DVW-1:0]  frm_div;

    logic          cmd_reg;
    logic [7:0]    pix_reg;
    logic [CW-1:0] in_col_reg;
    logic [RW-1:0] in_row_reg;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] out_idx_reg;
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] out_row_reg;
    logic [BW-1:0] win_i_reg;
    logic [BW-1:0] win_j_reg;
    logic          acc_en_reg;
    logic          border_reg;
    logic [SW-1:0] sum_reg;
    logic [PW-1:0] prod_reg;
    logic          tneg_reg;
    logic          m_tvalid_reg;
    logic [7:0]    m_tdata_reg;
    logic          m_tlast_reg;

    logic            latch;
    logic            latch_cond;
    logic            write_ok;
    logic            emit_write;
    logic            emit_flush;
    logic            interior;
    logic            win_last;
    logic            out_free;
    logic [CNTW-1:0] count_inc;
    logic [CNTW-1:0] lag_now;
    logic [CNTW-1:0] out_inc;
    logic [BW-1:0]   span;
    logic [XW-1:0]   rr;
    logic [CW-1:0]   cc;
    logic [XW-1:0]   in_row_ext;
    logic [XW-1:0]   out_row_ext;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    logic [7:0]      mem_rdata;
    logic signed [10:0] t_val;
    logic [7:0]      result_pix;

    amt_frame_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .latch    (latch),
        .frm_w    (frm_w),
        .frm_h    (frm_h),
        .frm_half (frm_half),
        .frm_off  (frm_off),
        .frm_total(frm_total),
        .frm_delay(frm_delay),
        .frm_div  (frm_div)
    );

    amt_line_store #(
        .AW(AW)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (mem_we),
        .wr_addr(mem_waddr),
        .wr_data(pix_reg),
        .rd_addr(mem_raddr),
        .rd_data(mem_rdata)
    );

    always_comb begin
        latch_cond = (s_tuser == amt_pkg::CMD_PIXEL) && (count_reg == '0)
                     && (out_idx_reg == '0);
        count_inc  = count_reg + CNTW'(1);
        out_inc    = out_idx_reg + CNTW'(1);
        lag_now    = count_inc - out_idx_reg;
        write_ok   = (cmd_reg == amt_pkg::CMD_PIXEL) && (count_reg < frm_total);
        emit_write = 32'(lag_now) > 32'(frm_delay);
        emit_flush = (count_reg >= frm_total) && (out_idx_reg < frm_total);
        interior   = (32'(out_row_reg) >= 32'(frm_half))
                     && (32'(out_row_reg) + 32'(frm_half) + 32'd1 < 32'(frm_h))
                     && (32'(out_col_reg) >= 32'(frm_half))
                     && (32'(out_col_reg) + 32'(frm_half) + 32'd1 < 32'(frm_w));
        span       = frm_half << 1;
        win_last   = (win_i_reg == span) && (win_j_reg == span);
        out_free   = !m_tvalid_reg || m_tready;
        rr          = XW'(out_row_reg) - XW'(frm_half) + XW'(win_i_reg);
        cc          = out_col_reg - CW'(frm_half) + CW'(win_j_reg);
        in_row_ext  = XW'(in_row_reg);
        out_row_ext = XW'(out_row_reg);
        mem_we      = (state_reg == amt_pkg::ST_DECIDE) && write_ok;
        mem_waddr   = {in_row_ext[RA-1:0], in_col_reg};
        if (state_reg == amt_pkg::ST_CENTER) begin
            mem_raddr = {out_row_ext[RA-1:0], out_col_reg};
        end else begin
            mem_raddr = {rr[RA-1:0], cc};
        end
        t_val = $signed({3'b000, mem_rdata}) + 11'(frm_off) + 11'sd1;
        if (border_reg) begin
            result_pix = amt_pkg::PIX_WHITE;
        end else if (tneg_reg || (32'(prod_reg) <= 32'(sum_reg))) begin
            result_pix = amt_pkg::PIX_BLACK;
        end else begin
            result_pix = amt_pkg::PIX_WHITE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= amt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        latch      = 1'b0;
        case (state_reg)
            amt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (latch_cond) begin
                        latch      = 1'b1;
                        state_next = amt_pkg::ST_LATCH;
                    end else begin
                        state_next = amt_pkg::ST_DECIDE;
                    end
                end
            end
            amt_pkg::ST_LATCH:  state_next = amt_pkg::ST_CALC;
            amt_pkg::ST_CALC:   state_next = amt_pkg::ST_DECIDE;
            amt_pkg::ST_DECIDE: begin
                if (write_ok ? emit_write : emit_flush) begin
                    state_next = interior ? amt_pkg::ST_READ : amt_pkg::ST_RESULT;
                end else begin
                    state_next = amt_pkg::ST_IDLE;
                end
            end
            amt_pkg::ST_READ: begin
                if (win_last) begin
                    state_next = amt_pkg::ST_CENTER;
                end
            end
            amt_pkg::ST_CENTER: state_next = amt_pkg::ST_MUL;
            amt_pkg::ST_MUL:    state_next = amt_pkg::ST_RESULT;
            amt_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = amt_pkg::ST_IDLE;
                end
            end
            default: state_next = amt_pkg::ST_IDLE;
        endcase
    end

    // payload and window datapath
    always_ff @(posedge aclk) begin
        if (state_reg == amt_pkg::ST_IDLE && s_tvalid) begin
            cmd_reg <= s_tuser;
            pix_reg <= s_tdata;
        end
        if (state_reg == amt_pkg::ST_DECIDE) begin
            sum_reg    <= '0;
            border_reg <= !interior;
        end else if (acc_en_reg) begin
            sum_reg <= sum_reg + SW'(mem_rdata);
        end
        if (state_reg == amt_pkg::ST_MUL) begin
            prod_reg <= PW'(t_val[9:0]) * PW'(frm_div);
            tneg_reg <= (t_val <= 11'sd0);
        end
        if (state_reg == amt_pkg::ST_RESULT && out_free) begin
            m_tdata_reg <= result_pix;
            m_tlast_reg <= (out_inc == frm_total);
        end
    end

    // position counters and handshake state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            count_reg    <= '0;
            out_idx_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            win_i_reg    <= '0;
            win_j_reg    <= '0;
            acc_en_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == amt_pkg::ST_RESULT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                amt_pkg::ST_DECIDE: begin
                    win_i_reg <= '0;
                    win_j_reg <= '0;
                    if (write_ok) begin
                        count_reg <= count_inc;
                        if (32'(in_col_reg) + 32'd1 >= 32'(frm_w)) begin
                            in_col_reg <= '0;
                            in_row_reg <= in_row_reg + RW'(1);
                        end else begin
                            in_col_reg <= in_col_reg + CW'(1);
                        end
                    end
                end
                amt_pkg::ST_READ: begin
                    acc_en_reg <= 1'b1;
                    if (win_j_reg == span) begin
                        win_j_reg <= '0;
                        win_i_reg <= win_i_reg + BW'(1);
                    end else begin
                        win_j_reg <= win_j_reg + BW'(1);
                    end
                end
                amt_pkg::ST_CENTER: acc_en_reg <= 1'b0;
                amt_pkg::ST_RESULT: begin
                    if (out_free) begin
                        // frame done: rewind every position
                        if (out_inc >= frm_total) begin
                            in_col_reg  <= '0;
                            in_row_reg  <= '0;
                            count_reg   <= '0;
                            out_idx_reg <= '0;
                            out_col_reg <= '0;
                            out_row_reg <= '0;
                        end else begin
                            out_idx_reg <= out_inc;
                            if (32'(out_col_reg) + 32'd1 >= 32'(frm_w)) begin
                                out_col_reg <= '0;
                                out_row_reg <= out_row_reg + RW'(1);
                            end else begin
                                out_col_reg <= out_col_reg + CW'(1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

@@ hdl/amt_line_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amt_line_store
// Ring of pixel rows: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module amt_line_store #(
    parameter int AW = 15
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

@@ hdl/amt_frame_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amt_frame_cfg
// Configuration registers, per-frame latch with range clamping, and the
// derived frame figures (pixel total, output lag, window divisor).
// ----------------------------------------------------------------------------
module amt_frame_cfg #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_BLOCK  = 31
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [amt_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [amt_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                                   latch,
    output logic [$clog2(MAX_WIDTH+1)-1:0]              frm_w,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]             frm_h,
    output logic [$clog2(MAX_BLOCK+1)-1:0]              frm_half,
    output logic signed [8:0]                           frm_off,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0]   frm_total,
    output logic [$clog2(MAX_WIDTH+1)+$clog2(MAX_BLOCK+1)-1:0] frm_delay,
    output logic [2*$clog2(MAX_BLOCK+1)-1:0]            frm_div
);

    localparam int WW   = $clog2(MAX_WIDTH+1);
    localparam int HW   = $clog2(MAX_HEIGHT+1);
    localparam int BW   = $clog2(MAX_BLOCK+1);
    localparam int CNTW = $clog2(MAX_WIDTH*MAX_HEIGHT+1);

    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [4:0]  block_reg;
    logic [8:0]  offset_reg;

    logic [WW-1:0] w_sat;
    logic [HW-1:0] h_sat;
    logic [BW-1:0] b_sat;
    logic [BW-1:0] frm_b_reg;
    logic          calc_reg;

    logic [WW+HW-1:0] area;
    logic [WW+BW-1:0] lag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= amt_pkg::RST_IMAGE_WIDTH;
            height_reg <= amt_pkg::RST_IMAGE_HEIGHT;
            block_reg  <= amt_pkg::RST_BLOCK_SIZE;
            offset_reg <= amt_pkg::RST_OFFSET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                amt_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                amt_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                amt_pkg::REG_BLOCK_SIZE:   block_reg  <= cfg_data[4:0];
                amt_pkg::REG_OFFSET:       offset_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == 11'd0) begin
            w_sat = WW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_sat = WW'(MAX_WIDTH);
        end else begin
            w_sat = WW'(width_reg);
        end
        if (height_reg == 11'd0) begin
            h_sat = HW'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_sat = HW'(MAX_HEIGHT);
        end else begin
            h_sat = HW'(height_reg);
        end
        if (block_reg == 5'd0) begin
            b_sat = BW'(1);
        end else if (32'(block_reg) > MAX_BLOCK) begin
            b_sat = BW'(MAX_BLOCK);
        end else begin
            b_sat = BW'(block_reg);
        end
    end

    assign area = (WW+HW)'(frm_w) * (WW+HW)'(frm_h);
    assign lag  = (WW+BW)'(frm_half) * (WW+BW)'(frm_w) + (WW+BW)'(frm_half);

    always_ff @(posedge aclk) begin
        if (latch) begin
            frm_w     <= w_sat;
            frm_h     <= h_sat;
            frm_b_reg <= b_sat;
            frm_half  <= b_sat >> 1;
            frm_off   <= $signed(offset_reg);
        end
        if (calc_reg) begin
            frm_delay <= lag;
            frm_div   <= (2*BW)'(frm_b_reg) * (2*BW)'(frm_b_reg);
        end
    end

    // derived figures follow in the cycle after the latch (calc_reg)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calc_reg  <= 1'b0;
            frm_total <= CNTW'(1);
        end else begin
            calc_reg <= latch;
            if (calc_reg) begin
                frm_total <= CNTW'(area);
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/amt_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amt_checker
// Port-level checks of the adaptive mean threshold block.
// ----------------------------------------------------------------------------
module amt_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_binary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == 8'h00 || m_tdata == 8'hFF))
        else $error("result is not binary");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

    // one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while busy");

endmodule

bind adaptive_mean_threshold amt_checker u_amt_checker (.*);
`default_nettype wire
